// ===== hdl/palette_pixel_expander_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the palette pixel expander
// Concurrent checks that compile away when NO_ASSERTIONS is defined.
// ----------------------------------------------------------------------------
`ifndef PALETTE_PIXEL_EXPANDER_UNIT_ASSERT_SVH
`define PALETTE_PIXEL_EXPANDER_UNIT_ASSERT_SVH

`ifndef NO_ASSERTIONS

// Antecedent implies consequent in the same cycle.
`define PPE_ASSERT_NOW(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |-> (cons)) \
    else $error("assertion failed");

// Antecedent implies consequent in the next cycle.
`define PPE_ASSERT_NEXT(lbl, ck, rs, ante, cons) \
  lbl: assert property (@(posedge ck) disable iff (rs) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define PPE_ASSERT_NOW(lbl, ck, rs, ante, cons)
`define PPE_ASSERT_NEXT(lbl, ck, rs, ante, cons)

`endif

`endif

// ===== hdl/ppe_pkg.sv =====
// ----------------------------------------------------------------------------
// Palette pixel expander package
// Shared constants, register codes and the structs passed between units.
// ----------------------------------------------------------------------------
package ppe_pkg;

  localparam int PALETTE_ENTRIES = 256;
  localparam int PAL_AW          = $clog2(PALETTE_ENTRIES);
  localparam int COL_W           = 13;
  localparam int BYTE_CNT_W      = 12;
  localparam int PIX_PER_BYTE_W  = 4;

  localparam logic [COL_W-1:0] MAX_ROW_WIDTH = 13'd4096;
  localparam logic [15:0]      ROW_ALIGN_RND = 16'd31;  // round up to 32 bits

  // depth mode codes; the unused code behaves as 8 bits per pixel
  localparam logic [1:0] DEPTH_1BPP = 2'd0;
  localparam logic [1:0] DEPTH_4BPP = 2'd1;
  localparam logic [1:0] DEPTH_8BPP = 2'd2;

  // configuration register indexes
  localparam logic CFG_DEPTH_MODE = 1'b0;
  localparam logic CFG_ROW_WIDTH  = 1'b1;

  // input kind carried on tuser
  localparam logic ACT_PAL_WRITE = 1'b0;
  localparam logic ACT_DATA_BYTE = 1'b1;

  typedef struct packed {
    logic [PIX_PER_BYTE_W-1:0] npix;     // pixels this byte yields, 0..8
    logic                      row_end;  // last yielded pixel closes the row
  } byte_plan_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] idx;
    logic [23:0]       rgb;  // red, green, blue from high to low
  } pal_wr_t;

  typedef struct packed {
    logic              en;
    logic [PAL_AW-1:0] idx;
    logic              last_of_byte;
    logic              row_done;
  } pix_req_t;

endpackage

// ===== hdl/ppe_row_track.sv =====
// ----------------------------------------------------------------------------
// Row position tracker
// Holds the depth and width registers and the position in the source row.
// ----------------------------------------------------------------------------
module ppe_row_track (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic                    cfg_index,
  input  logic [12:0]             cfg_data,
  input  logic                    advance,
  output logic [1:0]              depth_mode,
  output ppe_pkg::byte_plan_t     plan
);
  import ppe_pkg::*;

  logic [1:0]            mode;
  logic [COL_W-1:0]      row_width;
  logic [COL_W-1:0]      col;
  logic [BYTE_CNT_W-1:0] byte_cnt;

  logic [COL_W-1:0]          eff_w;
  logic [PIX_PER_BYTE_W-1:0] per_byte;
  logic [15:0]               row_bits;
  logic [15:0]               row_bits_rnd;
  logic [COL_W-1:0]          stride;
  logic [COL_W-1:0]          cnt_inc;
  logic                      wrap;
  logic [COL_W:0]            col_sum;
  logic [COL_W-1:0]          col_next;
  logic [COL_W-1:0]          left;

  always_comb begin
    if (row_width == '0) begin
      eff_w = 13'd1;
    end else if (row_width > MAX_ROW_WIDTH) begin
      eff_w = MAX_ROW_WIDTH;
    end else begin
      eff_w = row_width;
    end

    case (mode)
      DEPTH_1BPP: begin
        per_byte = 4'd8;
        row_bits = {3'b000, eff_w};
      end
      DEPTH_4BPP: begin
        per_byte = 4'd2;
        row_bits = {1'b0, eff_w, 2'b00};
      end
      default: begin
        per_byte = 4'd1;
        row_bits = {eff_w, 3'b000};
      end
    endcase

    row_bits_rnd = row_bits + ROW_ALIGN_RND;
    stride       = {row_bits_rnd[15:5], 2'b00};
    cnt_inc      = {1'b0, byte_cnt} + 13'd1;
    wrap         = cnt_inc >= stride;

    col_sum  = {1'b0, col} + {10'd0, per_byte};
    col_next = (col_sum >= {1'b0, eff_w}) ? eff_w : col_sum[COL_W-1:0];

    left = eff_w - col;
    if (col < eff_w) begin
      plan.row_end = left <= {9'd0, per_byte};
      plan.npix    = plan.row_end ? left[PIX_PER_BYTE_W-1:0] : per_byte;
    end else begin
      plan.row_end = 1'b0;
      plan.npix    = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= DEPTH_8BPP;
      row_width <= 13'd1;
      col       <= '0;
      byte_cnt  <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DEPTH_MODE: mode      <= cfg_data[1:0];
        CFG_ROW_WIDTH:  row_width <= cfg_data;
        default:        mode      <= mode;
      endcase
      col      <= '0;
      byte_cnt <= '0;
    end else if (advance) begin
      if (wrap) begin
        col      <= '0;
        byte_cnt <= '0;
      end else begin
        col      <= col_next;
        byte_cnt <= cnt_inc[BYTE_CNT_W-1:0];
      end
    end
  end

  assign depth_mode = mode;

endmodule

// ===== hdl/ppe_unpack.sv =====
// ----------------------------------------------------------------------------
// Byte unpacker
// Holds one accepted item and issues its pixels to the palette one a cycle while the result register is free.
// ----------------------------------------------------------------------------
module ppe_unpack (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic                  in_action,
  input  logic [39:0]           in_data,
  input  logic [1:0]            depth_mode,
  input  ppe_pkg::byte_plan_t   plan,
  input  logic                  out_free,
  output ppe_pkg::pal_wr_t      pal_wr,
  output ppe_pkg::pix_req_t     pix_req
);
  import ppe_pkg::*;

  logic                      held;
  logic                      is_data;
  logic [1:0]                mode;
  logic [7:0]                bits;
  logic [PIX_PER_BYTE_W-1:0] rem;
  logic                      row_end;
  logic [PAL_AW-1:0]         wr_idx;
  logic [23:0]               wr_rgb;

  logic       issue;
  logic       done;
  logic [7:0] bits_next;
  logic [7:0] pix_idx;

  always_comb begin
    case (mode)
      DEPTH_1BPP: begin
        pix_idx   = {7'd0, bits[7]};
        bits_next = {bits[6:0], 1'b0};
      end
      DEPTH_4BPP: begin
        pix_idx   = {4'd0, bits[7:4]};
        bits_next = {bits[3:0], 4'd0};
      end
      default: begin
        pix_idx   = bits;
        bits_next = '0;
      end
    endcase
  end

  assign issue    = held && is_data && (rem != '0) && out_free;
  assign done     = held && (!is_data || rem == '0 || (issue && rem == 4'd1));
  assign in_ready = !held || done;

  always_ff @(posedge clk) begin
    if (rst) begin
      held <= 1'b0;
    end else if (in_valid && in_ready) begin
      held <= 1'b1;
    end else if (done) begin
      held <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      is_data <= in_action == ACT_DATA_BYTE;
      mode    <= depth_mode;
      bits    <= in_data[39:32];
      rem     <= plan.npix;
      row_end <= plan.row_end;
      wr_idx  <= in_data[PAL_AW-1:0];
      wr_rgb  <= {in_data[15:8], in_data[23:16], in_data[31:24]};
    end else if (issue) begin
      bits <= bits_next;
      rem  <= rem - 4'd1;
    end
  end

  // palette write fires in the single cycle the write item is held
  assign pal_wr.en  = held && !is_data;
  assign pal_wr.idx = wr_idx;
  assign pal_wr.rgb = wr_rgb;

  assign pix_req.en           = issue;
  assign pix_req.idx          = pix_idx[PAL_AW-1:0];
  assign pix_req.last_of_byte = rem == 4'd1;
  assign pix_req.row_done     = (rem == 4'd1) && row_end;

endmodule

// ===== hdl/ppe_palette.sv =====
// ----------------------------------------------------------------------------
// Palette store and result register
// 256 x 24 palette memory whose registered read port is the output stage.
// ----------------------------------------------------------------------------
module ppe_palette (
  input  logic               clk,
  input  logic               rst,
  input  ppe_pkg::pal_wr_t   pal_wr,
  input  ppe_pkg::pix_req_t  pix_req,
  input  logic               out_ready,
  output logic               out_valid,
  output logic               out_free,
  output logic [23:0]        out_rgb,
  output logic               out_last_of_byte,
  output logic               out_row_done
);
  import ppe_pkg::*;

  logic [23:0] mem [PALETTE_ENTRIES];

  always_ff @(posedge clk) begin
    if (pal_wr.en) begin
      mem[pal_wr.idx] <= pal_wr.rgb;
    end
    if (pix_req.en) begin
      out_rgb          <= mem[pix_req.idx];
      out_last_of_byte <= pix_req.last_of_byte;
      out_row_done     <= pix_req.row_done;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pix_req.en) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  assign out_free = !out_valid || out_ready;

endmodule

// ===== hdl/palette_pixel_expander_unit.sv =====
// ----------------------------------------------------------------------------
// Palette pixel expander
// Expands packed 1, 4 or 8 bit indexed pixel rows into 24-bit color.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream carries requests: s_tuser low writes palette entry
//   s_tdata[7:0] with red, green, blue; s_tuser high delivers one packed
//   row byte in s_tdata[39:32], most significant pixel first.
//   The master stream carries one pixel per transfer: blue, green, red in
//   m_tdata, m_tuser on the last pixel of its byte, m_tlast on the last
//   pixel of the row. Padding bytes and bits past the row width yield none.
//   The first pixel of a byte passes the unpacker hold register and the
//   palette read register before it is valid on the master side.
//   Throughput: one pixel per cycle while the master side does not stall,
//   set by the single palette read port. Config writes (cfg_we) must be
//   issued only while idle; the block itself does not enforce this. Each
//   config write restarts the row.
//   Reset clears the row position and sets 8 bpp and a width of one; the
//   palette holds garbage until written.
//   When m_tready is low the result register holds and the unpacker stalls;
//   a new request is still taken while the unpacker is empty.
// ----------------------------------------------------------------------------
`include "palette_pixel_expander_unit_assert.svh"

module palette_pixel_expander_unit (
  input  logic        clk,
  input  logic        rst,
  // configuration write port
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [12:0] cfg_data,
  // request stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [39:0] s_tdata,   // palette_index, red_in, green_in, blue_in, data_byte
  input  logic        s_tuser,   // action
  // pixel stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // blue_out, green_out, red_out
  output logic        m_tuser,   // last_of_byte
  output logic        m_tlast    // row_done
);
  import ppe_pkg::*;

  logic       [1:0] depth_mode;
  byte_plan_t       plan;
  pal_wr_t          pal_wr;
  pix_req_t         pix_req;
  logic             out_free;
  logic [23:0]      rgb;

  // row position advances once per accepted data byte, in arrival order
  ppe_row_track u_row (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .advance    (s_tvalid && s_tready && s_tuser == ACT_DATA_BYTE),
    .depth_mode (depth_mode),
    .plan       (plan)
  );

  // hold the current request and issue its pixels
  ppe_unpack u_unpack (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_tvalid),
    .in_ready   (s_tready),
    .in_action  (s_tuser),
    .in_data    (s_tdata),
    .depth_mode (depth_mode),
    .plan       (plan),
    .out_free   (out_free),
    .pal_wr     (pal_wr),
    .pix_req    (pix_req)
  );

  // look up the color; the read register drives the master side
  ppe_palette u_pal (
    .clk              (clk),
    .rst              (rst),
    .pal_wr           (pal_wr),
    .pix_req          (pix_req),
    .out_ready        (m_tready),
    .out_valid        (m_tvalid),
    .out_free         (out_free),
    .out_rgb          (rgb),
    .out_last_of_byte (m_tuser),
    .out_row_done     (m_tlast)
  );

  // palette packs red high, blue low, which is the output order
  assign m_tdata = rgb;

  // a pixel is only issued into a free result register
  `PPE_ASSERT_NOW(a_issue_into_free, clk, rst, pix_req.en, !m_tvalid || m_tready)
  // a row end always closes the byte that carries it
  `PPE_ASSERT_NOW(a_row_done_last, clk, rst, m_tvalid && m_tlast, m_tuser)
  // a palette write never overlaps a pixel read
  `PPE_ASSERT_NOW(a_wr_rd_apart, clk, rst, pal_wr.en, !pix_req.en)
  // a freshly issued pixel shows up on the master side
  `PPE_ASSERT_NEXT(a_issue_valid, clk, rst, pix_req.en, m_tvalid)

endmodule
